FILE: src/rhcs_pkg.sv
// Shared types, constants and helper functions for the RGB hue color segmenter.
// Used by rhcs_front, rhcs_div_cell, rhcs_back and rgb_hue_color_segmenter.
package rhcs_pkg;

    localparam int DivSteps = 7;   // quotient bits of 255*min/sum, which never exceeds 85

    localparam logic [7:0] HueNone      = 8'd255;
    localparam logic [7:0] HueBaseRed   = 8'd42;
    localparam logic [7:0] HueBaseGreen = 8'd126;
    localparam logic [7:0] HueBaseBlue  = 8'd210;
    localparam logic [7:0] HueStep      = 8'd42;
    localparam logic [7:0] WhiteSatMax  = 8'd50;
    localparam logic [7:0] SatFull      = 8'd255;
    localparam logic [DivSteps-1:0] QuoMax = DivSteps'(85);

    // floor(sum/3) == (sum * 683) >> 11 for every sum up to 765
    localparam logic [9:0] RecipThird = 10'd683;
    localparam int         RecipShift = 11;

    // configuration register indexes
    localparam logic [3:0] CfgRedHueMax   = 4'd0;
    localparam logic [3:0] CfgRedSatMin   = 4'd1;
    localparam logic [3:0] CfgRedIntMin   = 4'd2;
    localparam logic [3:0] CfgBlueIntLow  = 4'd3;
    localparam logic [3:0] CfgBlueIntHigh = 4'd4;
    localparam logic [3:0] CfgBlueHueLow  = 4'd5;
    localparam logic [3:0] CfgBlueHueHigh = 4'd6;
    localparam logic [3:0] CfgWhiteIntMin = 4'd7;

    typedef struct packed {
        logic [7:0] red_hue_max;
        logic [7:0] red_sat_min;
        logic [7:0] red_int_min;
        logic [7:0] blue_int_low;
        logic [7:0] blue_int_high;
        logic [7:0] blue_hue_low;
        logic [7:0] blue_hue_high;
        logic [7:0] white_int_min;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        red_hue_max:   8'd45,
        red_sat_min:   8'd50,
        red_int_min:   8'd25,
        blue_int_low:  8'd35,
        blue_int_high: 8'd75,
        blue_hue_low:  8'd180,
        blue_hue_high: 8'd250,
        white_int_min: 8'd130
    };

    // word handed from cell to cell along the divider chain
    typedef struct packed {
        logic [7:0]          hue;
        logic [7:0]          inten;
        logic                black;
        logic [9:0]          den;   // channel sum
        logic [9:0]          rem;   // partial remainder, below den or zero for a black pixel
        logic [DivSteps-1:0] num;   // dividend bits still to bring down, MSB next
        logic [DivSteps-1:0] quo;   // quotient bits so far
    } t_pix_word;

    // base plus or minus one hue step when the difference equals +/- spread
    function automatic logic [7:0] hue_term(logic [7:0] base, logic [7:0] a,
                                            logic [7:0] c, logic [7:0] spread);
        logic [8:0] d_pos;
        logic [8:0] d_neg;
        d_pos = {1'b0, a} - {1'b0, c};
        d_neg = {1'b0, c} - {1'b0, a};
        if (d_pos == {1'b0, spread}) begin
            return base + HueStep;
        end else if (d_neg == {1'b0, spread}) begin
            return base - HueStep;
        end else begin
            return base;
        end
    endfunction

endpackage

FILE: src/rhcs_front.sv
// Front stage: channel max/min, hue code, intensity and divider operands.
// Depends on rhcs_pkg.
module rhcs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhcs_pkg::t_pix_word  o_word
);

    logic                r_valid;
    rhcs_pkg::t_pix_word r_word;
    rhcs_pkg::t_pix_word n_word;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  spread;
    logic [9:0]  sum;
    logic [15:0] dividend;
    logic [19:0] third;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        spread   = mx - mn;
        sum      = {2'b00, i_red} + {2'b00, i_green} + {2'b00, i_blue};
        dividend = {mn, 8'h00} - {8'h00, mn};
        third    = {10'd0, sum} * {10'd0, rhcs_pkg::RecipThird};

        priority if ({spread, 1'b0} <= {1'b0, mx}) begin
            n_word.hue = rhcs_pkg::HueNone;
        end else if (i_red == mx) begin
            n_word.hue = rhcs_pkg::hue_term(rhcs_pkg::HueBaseRed, i_green, i_blue, spread);
        end else if (i_green == mx) begin
            n_word.hue = rhcs_pkg::hue_term(rhcs_pkg::HueBaseGreen, i_blue, i_red, spread);
        end else begin
            n_word.hue = rhcs_pkg::hue_term(rhcs_pkg::HueBaseBlue, i_red, i_green, spread);
        end

        n_word.inten = third[rhcs_pkg::RecipShift +: 8];
        n_word.black = (mx == 8'd0);
        n_word.den   = sum;
        n_word.rem   = {1'b0, dividend[15:rhcs_pkg::DivSteps]};
        n_word.num   = dividend[rhcs_pkg::DivSteps-1:0];
        n_word.quo   = '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: src/rhcs_div_cell.sv
// One restoring-division cell: bring down a dividend bit, subtract if it fits.
// Depends on rhcs_pkg.
module rhcs_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rhcs_pkg::t_pix_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhcs_pkg::t_pix_word  o_word
);

    logic                r_valid;
    rhcs_pkg::t_pix_word r_word;
    rhcs_pkg::t_pix_word n_word;
    logic [10:0]         trial;
    logic [10:0]         diff;
    logic                fits;

    always_comb begin
        trial  = {i_word.rem, i_word.num[rhcs_pkg::DivSteps-1]};
        diff   = trial - {1'b0, i_word.den};
        fits   = (trial >= {1'b0, i_word.den});
        n_word = i_word;
        // remainder stays below den, or zero for a black pixel, so ten bits hold it
        n_word.rem = fits ? diff[9:0] : trial[9:0];
        n_word.num = {i_word.num[rhcs_pkg::DivSteps-2:0], 1'b0};
        n_word.quo = {i_word.quo[rhcs_pkg::DivSteps-2:0], fits};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: src/rhcs_back.sv
// Back stage: saturation from the quotient, threshold tests, output register.
// Depends on rhcs_pkg.
module rhcs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rhcs_pkg::t_pix_word  i_word,
    input  rhcs_pkg::t_cfg       i_cfg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_hue,
    output logic [7:0]           o_sat,
    output logic [7:0]           o_inten,
    output logic                 o_fg
);

    logic       r_valid;
    logic [7:0] r_hue;
    logic [7:0] r_sat;
    logic [7:0] r_inten;
    logic       r_fg;

    logic [7:0] n_sat;
    logic       n_fg;
    logic [7:0] quo3;
    logic       red_hit;
    logic       blue_hit;
    logic       white_hit;

    always_comb begin
        quo3  = {1'b0, i_word.quo} + {i_word.quo, 1'b0};
        n_sat = i_word.black ? 8'd0 : rhcs_pkg::SatFull - quo3;

        red_hit   = (i_word.hue <= i_cfg.red_hue_max) && (n_sat >= i_cfg.red_sat_min) &&
                    (i_word.inten > i_cfg.red_int_min);
        blue_hit  = (i_word.inten >= i_cfg.blue_int_low) &&
                    (i_word.inten <= i_cfg.blue_int_high) &&
                    (i_word.hue >= i_cfg.blue_hue_low) && (i_word.hue <= i_cfg.blue_hue_high);
        white_hit = (i_word.inten > i_cfg.white_int_min) && (n_sat <= rhcs_pkg::WhiteSatMax);
        n_fg      = red_hit || blue_hit || white_hit;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hue   <= i_word.hue;
            r_sat   <= n_sat;
            r_inten <= i_word.inten;
            r_fg    <= n_fg;
        end
    end

    assign o_valid = r_valid;
    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_inten = r_inten;
    assign o_fg    = r_fg;

endmodule

FILE: src/rgb_hue_color_segmenter.sv
// RGB hue color segmenter top level: front stage, divider cell chain, back stage.
// Stages: front, 7 divider cells, back, each ending in its own register.
// Throughput: one pixel per cycle unless the output stalls; every cell takes a new word each cycle it moves.
// The divider chain yields one quotient bit per cell.
// Reset (i_rst_n low, synchronous): all stage valids clear, thresholds load defaults.
// Depends on rhcs_pkg, rhcs_front, rhcs_div_cell, rhcs_back.
module rgb_hue_color_segmenter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,    // red [7:0], green [15:8], blue [23:16]
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // hue [7:0], saturation [15:8], intensity [23:16]
    output logic        o_m_tuser,    // foreground [0]
    // threshold register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int Steps = rhcs_pkg::DivSteps;

    // ------------------------------------------------------------------
    // Threshold registers. Writes are always taken; unknown indexes drop.
    // ------------------------------------------------------------------
    rhcs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rhcs_pkg::CfgReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rhcs_pkg::CfgRedHueMax:   r_cfg.red_hue_max   <= i_cfg_data;
                rhcs_pkg::CfgRedSatMin:   r_cfg.red_sat_min   <= i_cfg_data;
                rhcs_pkg::CfgRedIntMin:   r_cfg.red_int_min   <= i_cfg_data;
                rhcs_pkg::CfgBlueIntLow:  r_cfg.blue_int_low  <= i_cfg_data;
                rhcs_pkg::CfgBlueIntHigh: r_cfg.blue_int_high <= i_cfg_data;
                rhcs_pkg::CfgBlueHueLow:  r_cfg.blue_hue_low  <= i_cfg_data;
                rhcs_pkg::CfgBlueHueHigh: r_cfg.blue_hue_high <= i_cfg_data;
                rhcs_pkg::CfgWhiteIntMin: r_cfg.white_int_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline links. Link 0 leaves the front stage, link k+1 leaves cell k.
    // Each stage takes a word when it is empty or its successor moves, so
    // bubbles collapse; while results wait, the input stays open until all fill.
    // ------------------------------------------------------------------
    logic                w_valid [0:Steps];
    logic                w_ready [0:Steps];
    rhcs_pkg::t_pix_word w_word  [0:Steps];

    rhcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_word  (w_word[0])
    );

    // divide 255*min by the channel sum, one quotient bit per cell
    for (genvar k = 0; k < Steps; k++) begin : g_cell
        rhcs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    logic [7:0] w_hue;
    logic [7:0] w_sat;
    logic [7:0] w_inten;
    logic       w_fg;

    rhcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[Steps]),
        .o_ready (w_ready[Steps]),
        .i_word  (w_word[Steps]),
        .i_cfg   (r_cfg),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_hue   (w_hue),
        .o_sat   (w_sat),
        .o_inten (w_inten),
        .o_fg    (w_fg)
    );

    assign o_m_tdata = {w_inten, w_sat, w_hue};
    assign o_m_tuser = w_fg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // the input only closes when the pipeline is full behind a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // 255*min/sum never exceeds 85 for a non-black pixel
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[Steps] && !w_word[Steps].black) |-> (w_word[Steps].quo <= rhcs_pkg::QuoMax))
        else $error("divider quotient out of range");

    // a black pixel leaves with zero saturation and zero intensity
    a_black_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[Steps] && w_ready[Steps] && w_word[Steps].black) |=>
        (o_m_tvalid && (o_m_tdata[15:8] == 8'd0) && (o_m_tdata[23:16] == 8'd0)))
        else $error("black pixel with nonzero saturation or intensity");

endmodule

FILE: tb/rhcs_seg_checker.sv
// Checker for the RGB hue color segmenter: watches pixel, result and register channels,
// predicts hue, saturation, intensity and foreground, and compares in arrival order.
// Depends on rhcs_pkg for the threshold struct, register indexes and hue constants.
module rhcs_seg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_pending,
    output int          o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] intensity;
        logic       foreground;
    } t_seg_result;

    localparam rhcs_pkg::t_cfg ThresholdDefaults = '{
        red_hue_max:   8'd45,
        red_sat_min:   8'd50,
        red_int_min:   8'd25,
        blue_int_low:  8'd35,
        blue_int_high: 8'd75,
        blue_hue_low:  8'd180,
        blue_hue_high: 8'd250,
        white_int_min: 8'd130
    };

    rhcs_pkg::t_cfg thresholds;
    t_seg_result    seg_expected[$];

    function automatic t_seg_result segment_pixel(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, rhcs_pkg::t_cfg th);
        int          mx;
        int          mn;
        int          spread;
        int          total;
        int          diff;
        logic [7:0]  base;
        t_seg_result res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        spread = mx - mn;
        total  = r + g + b;

        if (2 * spread <= mx) begin
            res.hue = rhcs_pkg::HueNone;
        end else begin
            // red wins ties, then green
            if (r == mx) begin
                base = rhcs_pkg::HueBaseRed;
                diff = int'(g) - int'(b);
            end else if (g == mx) begin
                base = rhcs_pkg::HueBaseGreen;
                diff = int'(b) - int'(r);
            end else begin
                base = rhcs_pkg::HueBaseBlue;
                diff = int'(r) - int'(g);
            end
            // truncated ratio is only nonzero when the difference spans the full spread
            if (diff == spread) res.hue = base + rhcs_pkg::HueStep;
            else if (diff == -spread) res.hue = base - rhcs_pkg::HueStep;
            else res.hue = base;
        end

        res.saturation = (total == 0) ? 8'd0 : 8'(255 - 3 * ((255 * mn) / total));
        res.intensity  = 8'(total / 3);

        if (res.hue <= th.red_hue_max && res.saturation >= th.red_sat_min &&
            res.intensity > th.red_int_min) begin
            res.foreground = 1'b1;
        end else if (res.intensity >= th.blue_int_low && res.intensity <= th.blue_int_high &&
                     res.hue >= th.blue_hue_low && res.hue <= th.blue_hue_high) begin
            res.foreground = 1'b1;
        end else if (res.intensity > th.white_int_min &&
                     res.saturation <= rhcs_pkg::WhiteSatMax) begin
            res.foreground = 1'b1;
        end else begin
            res.foreground = 1'b0;
        end
        return res;
    endfunction

    initial begin
        o_pending  = 0;
        o_failures = 0;
        thresholds = ThresholdDefaults;
    end

    always @(posedge i_clk) begin
        t_seg_result want;
        if (!i_rst_n) begin
            thresholds = ThresholdDefaults;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rhcs_pkg::CfgRedHueMax:   thresholds.red_hue_max   = i_cfg_data;
                    rhcs_pkg::CfgRedSatMin:   thresholds.red_sat_min   = i_cfg_data;
                    rhcs_pkg::CfgRedIntMin:   thresholds.red_int_min   = i_cfg_data;
                    rhcs_pkg::CfgBlueIntLow:  thresholds.blue_int_low  = i_cfg_data;
                    rhcs_pkg::CfgBlueIntHigh: thresholds.blue_int_high = i_cfg_data;
                    rhcs_pkg::CfgBlueHueLow:  thresholds.blue_hue_low  = i_cfg_data;
                    rhcs_pkg::CfgBlueHueHigh: thresholds.blue_hue_high = i_cfg_data;
                    rhcs_pkg::CfgWhiteIntMin: thresholds.white_int_min = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                seg_expected = {seg_expected,
                                segment_pixel(i_s_tdata[7:0], i_s_tdata[15:8],
                                              i_s_tdata[23:16], thresholds)};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (seg_expected.size() == 0) begin
                    $error("result word with no pixel outstanding: tdata %h tuser %b",
                           i_m_tdata, i_m_tuser);
                    o_failures++;
                end else begin
                    want = seg_expected[0];
                    seg_expected.delete(0);
                    if (i_m_tdata[7:0] !== want.hue) begin
                        $error("hue: expected %0d, got %0d", want.hue, i_m_tdata[7:0]);
                        o_failures++;
                    end
                    if (i_m_tdata[15:8] !== want.saturation) begin
                        $error("saturation: expected %0d, got %0d",
                               want.saturation, i_m_tdata[15:8]);
                        o_failures++;
                    end
                    if (i_m_tdata[23:16] !== want.intensity) begin
                        $error("intensity: expected %0d, got %0d",
                               want.intensity, i_m_tdata[23:16]);
                        o_failures++;
                    end
                    if (i_m_tuser !== want.foreground) begin
                        $error("foreground: expected %0d, got %0d", want.foreground, i_m_tuser);
                        o_failures++;
                    end
                end
            end
        end
        o_pending = seg_expected.size();
    end

endmodule

FILE: tb/tb_rgb_hue_color_segmenter.sv
// Testbench top for the RGB hue color segmenter: clock, reset, pixel and register stimulus,
// random source gaps and sink stalls, and the final verdict.
// Depends on rhcs_pkg, rgb_hue_color_segmenter and rhcs_seg_checker.
module tb_rgb_hue_color_segmenter;
    timeunit 1ns;
    timeprecision 1ps;

    // extra cycles after the last result before touching registers or ending;
    // the pipeline is 9 deep, so this covers anything still in flight
    localparam int         DrainCycles    = 12;
    localparam int         RandomPerPhase = 190;
    // first register index past the defined set; writes there must be dropped
    localparam logic [3:0] CfgSpareBase   = 4'd8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [7:0]  cfg_data;
    int          pending;
    int          failures;

    // when set, that side runs back to back with no idle cycles
    bit          src_steady;
    bit          sink_steady;

    always #5 clk = ~clk;

    rgb_hue_color_segmenter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rhcs_seg_checker u_seg_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    // Offer one pixel word after a random gap and hold it until accepted.
    // Valid is left high on return so a gapless next word keeps the bus busy.
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = src_steady ? 0 : $urandom_range(16, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and hold off until every predicted result has come back,
    // then let the pipeline empty completely.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Offer one register word; valid stays high for a following write.
    task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Load every threshold while idle, plus one write to an undefined index
    // that must leave all thresholds untouched.
    task automatic load_thresholds(input rhcs_pkg::t_cfg th);
        settle();
        write_reg(rhcs_pkg::CfgRedHueMax,   th.red_hue_max);
        write_reg(rhcs_pkg::CfgRedSatMin,   th.red_sat_min);
        write_reg(rhcs_pkg::CfgRedIntMin,   th.red_int_min);
        write_reg(rhcs_pkg::CfgBlueIntLow,  th.blue_int_low);
        write_reg(rhcs_pkg::CfgBlueIntHigh, th.blue_int_high);
        write_reg(rhcs_pkg::CfgBlueHueLow,  th.blue_hue_low);
        write_reg(rhcs_pkg::CfgBlueHueHigh, th.blue_hue_high);
        write_reg(rhcs_pkg::CfgWhiteIntMin, th.white_int_min);
        write_reg(CfgSpareBase + 4'($urandom_range(7, 0)), 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic rhcs_pkg::t_cfg random_thresholds();
        rhcs_pkg::t_cfg th;
        th.red_hue_max   = 8'($urandom);
        th.red_sat_min   = 8'($urandom);
        th.red_int_min   = 8'($urandom);
        th.blue_int_low  = 8'($urandom);
        th.blue_int_high = 8'($urandom);
        th.blue_hue_low  = 8'($urandom);
        th.blue_hue_high = 8'($urandom);
        th.white_int_min = 8'($urandom);
        return th;
    endfunction

    // Mix of pixel shapes: plain random, near gray (achromatic edge), channel
    // ties (tie-break and full-spread hue steps), one dominant channel (sign
    // colors), and channels pinned at the rails.
    task automatic push_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] level;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(4, 0))
            0: ;
            1: begin
                level = 8'($urandom);
                r = level ^ 8'($urandom_range(7, 0));
                g = level ^ 8'($urandom_range(7, 0));
                b = level ^ 8'($urandom_range(7, 0));
            end
            2: begin
                case ($urandom_range(2, 0))
                    0: g = r;
                    1: b = g;
                    default: r = b;
                endcase
            end
            3: begin
                r = 8'($urandom_range(60, 0));
                g = 8'($urandom_range(60, 0));
                b = 8'($urandom_range(60, 0));
                case ($urandom_range(2, 0))
                    0: r = 8'($urandom_range(255, 100));
                    1: g = 8'($urandom_range(255, 100));
                    default: b = 8'($urandom_range(255, 100));
                endcase
            end
            default: begin
                if ($urandom_range(1, 0)) r = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                if ($urandom_range(1, 0)) g = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                if ($urandom_range(1, 0)) b = $urandom_range(1, 0) ? 8'hFF : 8'h00;
            end
        endcase
        push_pixel(r, g, b);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            // switch between gapped and back-to-back stretches
            if (i % 40 == 0) src_steady = ($urandom_range(3, 0) == 0);
            // occasionally stop and wait for the whole pipeline to come back
            if ($urandom_range(99, 0) == 0) settle();
            push_random_pixel();
        end
    endtask

    // Result sink: random stall before each word, with back-to-back stretches.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(39, 0) == 0) sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(16, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Main sequence.
    initial begin
        rhcs_pkg::t_cfg th;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels under the reset thresholds
        push_pixel(8'd0,   8'd0,   8'd0);      // black
        push_pixel(8'd255, 8'd255, 8'd255);    // brightest white
        push_pixel(8'd1,   8'd1,   8'd1);      // darkest nonblack gray
        push_pixel(8'd255, 8'd0,   8'd0);      // pure red
        push_pixel(8'd0,   8'd255, 8'd0);      // pure green
        push_pixel(8'd0,   8'd0,   8'd255);    // pure blue
        push_pixel(8'd255, 8'd255, 8'd0);      // red/green tie, hue steps up
        push_pixel(8'd0,   8'd255, 8'd255);    // green/blue tie, hue steps up
        push_pixel(8'd255, 8'd0,   8'd255);    // red/blue tie, hue steps down
        push_pixel(8'd100, 8'd50,  8'd50);     // achromatic right at the boundary
        push_pixel(8'd101, 8'd50,  8'd50);     // one past it
        push_pixel(8'd1,   8'd0,   8'd0);      // smallest chromatic pixel
        push_pixel(8'd0,   8'd1,   8'd1);
        push_pixel(8'd200, 8'd10,  8'd190);    // red max, partial difference
        push_pixel(8'd190, 8'd200, 8'd10);
        push_pixel(8'd10,  8'd20,  8'd200);
        push_pixel(8'd254, 8'd254, 8'd253);
        push_pixel(8'd140, 8'd140, 8'd140);    // white foreground
        push_pixel(8'd30,  8'd60,  8'd170);    // blue sign
        push_pixel(8'd200, 8'd40,  8'd30);     // red sign
        push_pixel(8'd128, 8'd128, 8'd127);
        push_pixel(8'd85,  8'd85,  8'd86);
        run_random(RandomPerPhase);

        // random thresholds
        load_thresholds(random_thresholds());
        run_random(RandomPerPhase);

        // all thresholds at zero
        load_thresholds('0);
        run_random(RandomPerPhase);

        // all thresholds at full scale; achromatic hue can pass the blue test
        load_thresholds('1);
        run_random(RandomPerPhase);

        // blue window open up to the achromatic code
        th = random_thresholds();
        th.blue_hue_high = rhcs_pkg::HueNone;
        th.blue_hue_low  = 8'($urandom_range(255, 150));
        th.blue_int_low  = 8'($urandom_range(40, 0));
        th.blue_int_high = 8'($urandom_range(255, 150));
        load_thresholds(th);
        run_random(RandomPerPhase);

        load_thresholds(random_thresholds());
        run_random(RandomPerPhase);

        settle();
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
src/rhcs_pkg.sv
src/rhcs_front.sv
src/rhcs_div_cell.sv
src/rhcs_back.sv
src/rgb_hue_color_segmenter.sv
tb/rhcs_seg_checker.sv
tb/tb_rgb_hue_color_segmenter.sv
